// File: hw/rtl/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB color converter.
// Depends on nothing; imported by hsv_to_rgb_integer.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int HUE_W            = 12;
    localparam int CH_W             = 13;
    localparam int UNITY_DEF        = 4096;
    localparam int SECTOR_STEPS_DEF = 660;
    localparam int NSTAGE           = 10;

    typedef enum logic [2:0] {
        SEC_RED_YEL   = 3'd0,
        SEC_YEL_GRN   = 3'd1,
        SEC_GRN_CYAN  = 3'd2,
        SEC_CYAN_BLUE = 3'd3,
        SEC_BLUE_MAG  = 3'd4,
        SEC_MAG_RED   = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // values that ride alongside the arithmetic
    typedef struct packed {
        sector_t         sector;
        logic [CH_W-1:0] value;
        logic [CH_W-1:0] chroma;
    } side_t;

endpackage

// File: hw/rtl/hsvrgb_cdiv.sv
// Three-stage pipelined divide of an unsigned word by a constant.
// Reciprocal multiply, back-multiply, one-step correction. No package use.
`timescale 1ns / 1ps

module hsvrgb_cdiv #(
    parameter int NUM_W  = 26,
    parameter int DIV    = 4096,
    parameter int QUOT_W = 13
) (
    input  logic              clk,
    input  logic [2:0]        en,
    input  logic [NUM_W-1:0]  num,
    output logic [QUOT_W-1:0] quot
);

    // estimate is floor(n*M / 2^NUM_W): at most one below the true quotient
    localparam longint unsigned MULT = (64'd1 << NUM_W) / DIV;
    localparam int MW = $clog2(MULT + 1);
    localparam int PW = NUM_W + MW;
    localparam int RW = $clog2(2 * DIV);

    logic [NUM_W-1:0]  num_a_reg;
    logic [PW-1:0]     prod_a_reg;
    logic [PW-1:0]     prod_a_next;
    logic [QUOT_W-1:0] q_b_reg;
    logic [QUOT_W-1:0] q_b_next;
    logic [RW-1:0]     rem_b_reg;
    logic [RW-1:0]     rem_b_next;
    logic [NUM_W-1:0]  back_prod;
    logic [QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0] quot_next;

    always_comb
    begin
        prod_a_next = PW'(num) * PW'(MULT);
        q_b_next    = QUOT_W'(prod_a_reg[PW-1:NUM_W]);
        back_prod   = NUM_W'(q_b_next) * NUM_W'(DIV);
        rem_b_next  = RW'(num_a_reg - back_prod);
        quot_next   = (rem_b_reg >= RW'(DIV)) ? QUOT_W'(q_b_reg + QUOT_W'(1)) : q_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            num_a_reg  <= num;
            prod_a_reg <= prod_a_next;
        end
        if (en[1])
        begin
            q_b_reg   <= q_b_next;
            rem_b_reg <= rem_b_next;
        end
        if (en[2])
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// File: hw/rtl/hsv_to_rgb_integer.sv
// Top level of the HSV to RGB converter: ten-stage pipeline with valid/ready.
// Depends on hsvrgb_pkg and hsvrgb_cdiv.
`timescale 1ns / 1ps

//  channel | payload | direction | handshake
//  --------+---------+-----------+----------------------
//  hsv     | hsv_t   | in        | hsv_valid / hsv_ready
//  rgb     | rgb_t   | out       | rgb_valid / rgb_ready
//
// One request per clock sustained while rgb_ready is high; rgb_valid rises once a
// request has passed ten register stages, the first loaded at the accepting edge
// (clamp/sector, products, a three-stage constant divider pair, weight product, a
// three-stage constant divider, channel select).
// Reset (rst_n low, asynchronous) clears the stage valid bits only.
// Each stage loads when empty or when the stage after it moves, so empty
// stages keep filling behind a stalled result and nothing is dropped or doubled.

module hsv_to_rgb_integer #(
    parameter int UNITY        = hsvrgb_pkg::UNITY_DEF,
    parameter int SECTOR_STEPS = hsvrgb_pkg::SECTOR_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hsv_valid,
    output logic              hsv_ready,
    input  hsvrgb_pkg::hsv_t  hsv,
    output logic              rgb_valid,
    input  logic              rgb_ready,
    output hsvrgb_pkg::rgb_t  rgb
);

    import hsvrgb_pkg::*;

    localparam int UW    = $clog2(UNITY + 1);     // holds UNITY itself
    localparam int FW    = $clog2(UNITY);         // fraction, below UNITY
    localparam int HM_W  = $clog2(6 * SECTOR_STEPS);
    localparam int CMP_W = (HM_W > HUE_W) ? HM_W : HUE_W;
    localparam int US_W  = (UW > CH_W) ? UW : CH_W;
    localparam int NF_W  = HUE_W + UW;            // remainder * UNITY
    localparam int SV_W  = 2 * CH_W;              // saturation * value
    localparam int P_W   = CH_W + UW;             // chroma * weight

    localparam logic [CMP_W-1:0] HUE_MAX = CMP_W'(6 * SECTOR_STEPS - 1);

    // ---------------------------------------------------------------
    // Stage handshake: stage k loads when empty or when k+1 loads.
    // ---------------------------------------------------------------
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE:0]   rdy;

    always_comb
    begin
        rdy[NSTAGE] = rgb_ready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= hsv_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign hsv_ready = rdy[0];
    assign rgb_valid = vld_reg[NSTAGE-1];

    // ---------------------------------------------------------------
    // Stage 0: clamp inputs, find sector and remainder within it.
    // ---------------------------------------------------------------
    logic [CMP_W-1:0] hue_ext;
    logic [CMP_W-1:0] hue_cl;
    logic [CMP_W-1:0] sec_base;
    logic [2:0]       sec_cnt;
    sector_t          sec0;
    logic [US_W-1:0]  sat_ext;
    logic [US_W-1:0]  val_ext;
    logic [CH_W-1:0]  sat_cl;
    logic [CH_W-1:0]  val_cl;
    logic [HUE_W-1:0] rem0_next;

    always_comb
    begin
        hue_ext = CMP_W'(hsv.hue);
        hue_cl  = (hue_ext > HUE_MAX) ? HUE_MAX : hue_ext;

        // sector = count of boundaries at or below hue
        sec_cnt = 3'd0;
        for (int k = 1; k < 6; k++)
        begin
            sec_cnt = sec_cnt + 3'((hue_cl >= CMP_W'(k * SECTOR_STEPS)) ? 1 : 0);
        end
        sec0 = sector_t'(sec_cnt);

        case (sec0)
            SEC_RED_YEL:   sec_base = '0;
            SEC_YEL_GRN:   sec_base = CMP_W'(SECTOR_STEPS);
            SEC_GRN_CYAN:  sec_base = CMP_W'(2 * SECTOR_STEPS);
            SEC_CYAN_BLUE: sec_base = CMP_W'(3 * SECTOR_STEPS);
            SEC_BLUE_MAG:  sec_base = CMP_W'(4 * SECTOR_STEPS);
            SEC_MAG_RED:   sec_base = CMP_W'(5 * SECTOR_STEPS);
            default:       sec_base = '0;
        endcase
        rem0_next = HUE_W'(hue_cl - sec_base);

        // saturate to full scale
        sat_ext = US_W'(hsv.saturation);
        val_ext = US_W'(hsv.brightness);
        sat_cl  = CH_W'((sat_ext > US_W'(UNITY)) ? US_W'(UNITY) : sat_ext);
        val_cl  = CH_W'((val_ext > US_W'(UNITY)) ? US_W'(UNITY) : val_ext);
    end

    // sideband shift line, stages 0..8
    side_t side_reg  [NSTAGE-1];
    side_t side_next [NSTAGE-1];

    logic [HUE_W-1:0] rem0_reg;
    logic [CH_W-1:0]  sat0_reg;
    logic [NF_W-1:0]  nfrac1_reg;
    logic [SV_W-1:0]  sv1_reg;
    logic [FW-1:0]    frac4;
    logic [CH_W-1:0]  chroma4;
    logic [UW-1:0]    weight5;
    logic [P_W-1:0]   prod5_reg;
    logic [CH_W-1:0]  second8;

    always_comb
    begin
        side_next[0].sector = sec0;
        side_next[0].value  = val_cl;
        side_next[0].chroma = '0;
        for (int k = 1; k < NSTAGE - 1; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[5].chroma = chroma4;   // chroma joins the sideband here
    end

    // ---------------------------------------------------------------
    // Stage 5 weight: rising edge in even sectors, falling in odd ones.
    // ---------------------------------------------------------------
    always_comb
    begin
        if (side_reg[4].sector[0])
        begin
            weight5 = UW'(UNITY) - UW'(frac4);
        end
        else
        begin
            weight5 = UW'(frac4);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTAGE - 1; k++)
        begin
            if (rdy[k])
            begin
                side_reg[k] <= side_next[k];
            end
        end
        if (rdy[0])
        begin
            rem0_reg <= rem0_next;
            sat0_reg <= sat_cl;
        end
        if (rdy[1])
        begin
            nfrac1_reg <= NF_W'(rem0_reg) * NF_W'(UNITY);
            sv1_reg    <= SV_W'(sat0_reg) * SV_W'(side_reg[0].value);
        end
        if (rdy[5])
        begin
            prod5_reg <= P_W'(chroma4) * P_W'(weight5);
        end
    end

    // ---------------------------------------------------------------
    // Stages 2..4: fraction = rem*UNITY/SECTOR_STEPS, chroma = s*v/UNITY.
    // ---------------------------------------------------------------
    hsvrgb_cdiv #(
        .NUM_W  (NF_W),
        .DIV    (SECTOR_STEPS),
        .QUOT_W (FW)
    ) u_div_frac (
        .clk  (clk),
        .en   (rdy[4:2]),
        .num  (nfrac1_reg),
        .quot (frac4)
    );

    hsvrgb_cdiv #(
        .NUM_W  (SV_W),
        .DIV    (UNITY),
        .QUOT_W (CH_W)
    ) u_div_chroma (
        .clk  (clk),
        .en   (rdy[4:2]),
        .num  (sv1_reg),
        .quot (chroma4)
    );

    // ---------------------------------------------------------------
    // Stages 6..8: secondary term = chroma*weight/UNITY.
    // ---------------------------------------------------------------
    hsvrgb_cdiv #(
        .NUM_W  (P_W),
        .DIV    (UNITY),
        .QUOT_W (CH_W)
    ) u_div_second (
        .clk  (clk),
        .en   (rdy[8:6]),
        .num  (prod5_reg),
        .quot (second8)
    );

    // ---------------------------------------------------------------
    // Stage 9: offset, top and mid levels routed by sector.
    // top = chroma + offset is simply the value.
    // ---------------------------------------------------------------
    logic [CH_W-1:0] lvl_base;
    logic [CH_W-1:0] lvl_top;
    logic [CH_W-1:0] lvl_mid;
    rgb_t            rgb_next;
    rgb_t            rgb_reg;

    always_comb
    begin
        lvl_top  = side_reg[8].value;
        lvl_base = side_reg[8].value - side_reg[8].chroma;
        lvl_mid  = second8 + lvl_base;
        case (side_reg[8].sector)
            SEC_RED_YEL:   rgb_next = '{red: lvl_top,  green: lvl_mid,  blue: lvl_base};
            SEC_YEL_GRN:   rgb_next = '{red: lvl_mid,  green: lvl_top,  blue: lvl_base};
            SEC_GRN_CYAN:  rgb_next = '{red: lvl_base, green: lvl_top,  blue: lvl_mid};
            SEC_CYAN_BLUE: rgb_next = '{red: lvl_base, green: lvl_mid,  blue: lvl_top};
            SEC_BLUE_MAG:  rgb_next = '{red: lvl_mid,  green: lvl_base, blue: lvl_top};
            default:       rgb_next = '{red: lvl_top,  green: lvl_base, blue: lvl_mid};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NSTAGE-1])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule
